@@ design/rle_rgb565_frame_decoder_defines.svh @@
// Assertion macros shared by the checker of the RLE RGB565 frame decoder.
// Each macro expects clk and rst to be visible where it is used.
`ifndef RLE_RGB565_FRAME_DECODER_DEFINES_SVH
`define RLE_RGB565_FRAME_DECODER_DEFINES_SVH

// Implication property, sampled on clk, off during reset.
`define RLEFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication property, sampled on clk, off during reset.
`define RLEFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/rlefd_pkg.sv @@
// Types and constants for the RLE RGB565 frame decoder.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package rlefd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_SIZE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_X_ORIGIN        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_ORIGIN        = 3'd4;

  // Register reset values
  localparam logic [15:0] EXPECTED_WIDTH_RST  = 16'd128;
  localparam logic [15:0] EXPECTED_HEIGHT_RST = 16'd96;
  localparam logic [9:0]  X_ORIGIN_RST        = 10'd0;
  localparam logic [9:0]  Y_ORIGIN_RST        = 10'd32;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_PULL  = 2'd1,
    OP_EOF   = 2'd2,
    OP_START = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_ZERO_RUN  = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_TRAILING  = 3'd5,
    ST_LEFTOVER  = 3'd6,
    ST_NOTREADY  = 3'd7
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        pixel_valid;
    logic [15:0] pixel_color;
    logic [16:0] pixel_x;
    logic [16:0] pixel_y;
    logic        frame_done;
    logic        need_byte;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/rle_rgb565_frame_decoder.sv @@
// Channel | Dir | Payload                      | Beat taken when
// in      | in  | rlefd_pkg::in_item_t         | in_valid && in_ready
// out     | out | rlefd_pkg::out_item_t        | out_valid && out_ready
// cfg     | in  | cfg_index (3b), cfg_data(16b)| cfg_valid && cfg_ready
//
// One beat per cycle in each direction while out_ready is high; a result appears in the
// cycle after its input beat, held in the single result register behind the decode logic.
// in_ready drops only while a result waits in that register with out_ready low.
// cfg is always ready. rst is synchronous, active high; it clears the frame
// state and loads the register defaults.
// Depends on rlefd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rle_rgb565_frame_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire rlefd_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output rlefd_pkg::out_item_t                     out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rlefd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rlefd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_RUNHDR,
    PH_PIXELS,
    PH_TAIL,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // configuration
  logic [15:0] expected_width;
  logic [15:0] expected_height;
  logic        check_size;
  logic [9:0]  x_origin;
  logic [9:0]  y_origin;

  // frame state
  phase_t             phase, phase_next;
  logic [1:0]         byte_index, byte_index_next;
  logic [23:0]        byte_gather, byte_gather_next;
  logic [15:0]        frame_width, frame_width_next;
  logic [15:0]        frame_height, frame_height_next;
  logic [15:0]        run_left, run_left_next;
  logic [15:0]        run_color, run_color_next;
  logic [15:0]        column, column_next;
  logic [15:0]        row, row_next;
  rlefd_pkg::status_t error_code, error_code_next;

  rlefd_pkg::out_item_t res;
  logic                 accept;
  logic [31:0]          word;
  logic [16:0]          col_inc;
  logic [15:0]          row_after;
  logic [15:0]          run_dec;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign word      = {in_data.data_byte, byte_gather};
  assign col_inc   = {1'b0, column} + 17'd1;
  assign row_after = (col_inc >= {1'b0, frame_width}) ? row + 16'd1 : row;
  assign run_dec   = run_left - 16'd1;

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    byte_gather_next  = byte_gather;
    frame_width_next  = frame_width;
    frame_height_next = frame_height;
    run_left_next     = run_left;
    run_color_next    = run_color;
    column_next       = column;
    row_next          = row;
    error_code_next   = error_code;
    res               = '0;
    res.status        = rlefd_pkg::ST_OK;

    if (in_data.opcode == rlefd_pkg::OP_START) begin
      phase_next        = PH_HEADER;
      byte_index_next   = 2'd0;
      byte_gather_next  = '0;
      frame_width_next  = '0;
      frame_height_next = '0;
      run_left_next     = '0;
      run_color_next    = '0;
      column_next       = '0;
      row_next          = '0;
      error_code_next   = rlefd_pkg::ST_OK;
    end else if (phase == PH_ERROR) begin
      res.status = error_code;
    end else begin
      unique case (in_data.opcode)
        rlefd_pkg::OP_DATA: begin
          if (phase == PH_HEADER || phase == PH_RUNHDR) begin
            if (byte_index != 2'd3) begin
              byte_index_next = byte_index + 2'd1;
              case (byte_index)
                2'd0:    byte_gather_next[7:0]   = in_data.data_byte;
                2'd1:    byte_gather_next[15:8]  = in_data.data_byte;
                default: byte_gather_next[23:16] = in_data.data_byte;
              endcase
            end else begin
              byte_index_next  = 2'd0;
              byte_gather_next = '0;
              if (phase == PH_HEADER) begin
                frame_width_next  = word[15:0];
                frame_height_next = word[31:16];
                if (word[15:0] == 16'd0 || word[31:16] == 16'd0) begin
                  res.status      = rlefd_pkg::ST_ZERO_SIZE;
                  error_code_next = rlefd_pkg::ST_ZERO_SIZE;
                  phase_next      = PH_ERROR;
                end else if (check_size && (word[15:0] != expected_width ||
                                            word[31:16] != expected_height)) begin
                  res.status      = rlefd_pkg::ST_MISMATCH;
                  error_code_next = rlefd_pkg::ST_MISMATCH;
                  phase_next      = PH_ERROR;
                end else begin
                  phase_next = PH_RUNHDR;
                end
              end else begin
                run_left_next  = word[15:0];
                run_color_next = word[31:16];
                if (word[15:0] == 16'd0) begin
                  res.status      = rlefd_pkg::ST_ZERO_RUN;
                  error_code_next = rlefd_pkg::ST_ZERO_RUN;
                  phase_next      = PH_ERROR;
                end else begin
                  phase_next = PH_PIXELS;
                end
              end
            end
          end else if (phase == PH_TAIL) begin
            res.status      = rlefd_pkg::ST_TRAILING;
            error_code_next = rlefd_pkg::ST_TRAILING;
            phase_next      = PH_ERROR;
          end else begin
            res.status = rlefd_pkg::ST_NOTREADY;
          end
        end
        rlefd_pkg::OP_PULL: begin
          if (phase == PH_PIXELS) begin
            // column < width and row < height hold here, so no underflow
            res.pixel_valid = 1'b1;
            res.pixel_color = run_color;
            res.pixel_x     = {7'd0, x_origin} + {1'b0, frame_width - 16'd1 - column};
            res.pixel_y     = {7'd0, y_origin} + {1'b0, frame_height - 16'd1 - row};
            run_left_next   = run_dec;
            row_next        = row_after;
            column_next     = (col_inc >= {1'b0, frame_width}) ? 16'd0 : col_inc[15:0];
            if (row_after >= frame_height) begin
              res.frame_done = 1'b1;
              if (run_dec != 16'd0) begin
                res.status      = rlefd_pkg::ST_LEFTOVER;
                error_code_next = rlefd_pkg::ST_LEFTOVER;
                phase_next      = PH_ERROR;
              end else begin
                phase_next = PH_TAIL;
              end
            end else if (run_dec == 16'd0) begin
              phase_next = PH_RUNHDR;
            end
          end else begin
            res.status = rlefd_pkg::ST_NOTREADY;
          end
        end
        default: begin
          // end of file
          if (phase == PH_HEADER || phase == PH_RUNHDR) begin
            res.status      = rlefd_pkg::ST_TRUNC;
            error_code_next = rlefd_pkg::ST_TRUNC;
            phase_next      = PH_ERROR;
          end else if (phase == PH_TAIL) begin
            phase_next     = PH_DONE;
            res.frame_done = 1'b1;
          end else begin
            res.status = rlefd_pkg::ST_NOTREADY;
          end
        end
      endcase
    end

    res.need_byte = (phase_next == PH_HEADER) || (phase_next == PH_RUNHDR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_width  <= rlefd_pkg::EXPECTED_WIDTH_RST;
      expected_height <= rlefd_pkg::EXPECTED_HEIGHT_RST;
      check_size      <= 1'b0;
      x_origin        <= rlefd_pkg::X_ORIGIN_RST;
      y_origin        <= rlefd_pkg::Y_ORIGIN_RST;
      phase           <= PH_HEADER;
      byte_index      <= 2'd0;
      byte_gather     <= '0;
      frame_width     <= '0;
      frame_height    <= '0;
      run_left        <= '0;
      run_color       <= '0;
      column          <= '0;
      row             <= '0;
      error_code      <= rlefd_pkg::ST_OK;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rlefd_pkg::CFG_EXPECTED_WIDTH:  expected_width  <= cfg_data;
          rlefd_pkg::CFG_EXPECTED_HEIGHT: expected_height <= cfg_data;
          rlefd_pkg::CFG_CHECK_SIZE:      check_size      <= cfg_data[0];
          rlefd_pkg::CFG_X_ORIGIN:        x_origin        <= cfg_data[9:0];
          rlefd_pkg::CFG_Y_ORIGIN:        y_origin        <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase        <= phase_next;
        byte_index   <= byte_index_next;
        byte_gather  <= byte_gather_next;
        frame_width  <= frame_width_next;
        frame_height <= frame_height_next;
        run_left     <= run_left_next;
        run_color    <= run_color_next;
        column       <= column_next;
        row          <= row_next;
        error_code   <= error_code_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
    if (accept) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

@@ design/rlefd_checker.sv @@
// Port-level checker for the RLE RGB565 frame decoder, bound to the top level.
// Depends on rlefd_pkg and rle_rgb565_frame_decoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rle_rgb565_frame_decoder_defines.svh"

module rlefd_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire rlefd_pkg::out_item_t out_data
);

  logic out_stall;
  logic no_pixel;
  logic pixel_zero;
  logic pixel_status_ok;
  logic notready;

  assign out_stall       = out_valid && !out_ready;
  assign no_pixel        = out_valid && !out_data.pixel_valid;
  assign pixel_zero      = out_data.pixel_color == 16'd0 && out_data.pixel_x == 17'd0 &&
                           out_data.pixel_y == 17'd0;
  assign pixel_status_ok = out_data.status == rlefd_pkg::ST_OK ||
                           out_data.status == rlefd_pkg::ST_LEFTOVER;
  assign notready        = out_valid && out_data.status == rlefd_pkg::ST_NOTREADY;

  // held result beat must not change
  `RLEFD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "held beat changed")

  // every input beat yields a result on the next cycle
  `RLEFD_ASSERT_NEXT(a_one_result, in_valid && in_ready, out_valid, "input beat produced no result")

  // no pixel means zero pixel fields
  `RLEFD_ASSERT_IMPL(a_no_pixel_zero, no_pixel, pixel_zero, "pixel fields set without a pixel")

  // a pixel only comes with ok or leftover-run status
  `RLEFD_ASSERT_IMPL(a_pixel_status, out_valid && out_data.pixel_valid, pixel_status_ok, "bad status")

  // a rejected request neither emits a pixel nor ends a frame
  `RLEFD_ASSERT_IMPL(a_notready_quiet, notready, !out_data.pixel_valid && !out_data.frame_done, "busy")

endmodule

bind rle_rgb565_frame_decoder rlefd_checker u_rlefd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/rle_rgb565_frame_decoder_tb.sv @@
// Self-checking testbench for rle_rgb565_frame_decoder: random frame streams with
// stalls on both channels, checked beat by beat against an in-bench decoder model.
// Depends on rlefd_pkg and the rle_rgb565_frame_decoder RTL.
`timescale 1ns / 1ps

module rle_rgb565_frame_decoder_tb;
  import rlefd_pkg::*;

  typedef enum logic [2:0] {
    DEC_HEADER,
    DEC_RUN_RECORD,
    DEC_PIXELS,
    DEC_TAIL,
    DEC_DONE,
    DEC_FAULT
  } dec_phase_e;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_ZERO_RUN,
    FRAME_LEFTOVER,
    FRAME_TRUNCATED,
    FRAME_TRAILING,
    FRAME_NOISE
  } frame_kind_e;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rle_rgb565_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  in_item_t    pending_beats[$];
  out_item_t   expected_results[$];
  int          fail_count = 0;
  int unsigned stim_items = 0;
  bit          no_idle = 1'b0;

  // Decoder model: settings and frame state
  logic [15:0] cfg_exp_w, cfg_exp_h;
  logic        cfg_check;
  logic [9:0]  cfg_x_org, cfg_y_org;
  dec_phase_e  dec_phase;
  logic [1:0]  byte_cnt;
  logic [23:0] byte_acc;
  logic [15:0] img_w, img_h, run_cnt, run_rgb, col_pos, row_pos;
  status_t     fault_code;

  function automatic void clear_decoder();
    dec_phase  = DEC_HEADER;
    byte_cnt   = '0;
    byte_acc   = '0;
    img_w      = '0;
    img_h      = '0;
    run_cnt    = '0;
    run_rgb    = '0;
    col_pos    = '0;
    row_pos    = '0;
    fault_code = ST_OK;
  endfunction

  function automatic void reset_decoder();
    cfg_exp_w = EXPECTED_WIDTH_RST;
    cfg_exp_h = EXPECTED_HEIGHT_RST;
    cfg_check = 1'b0;
    cfg_x_org = X_ORIGIN_RST;
    cfg_y_org = Y_ORIGIN_RST;
    clear_decoder();
  endfunction

  function automatic status_t raise_fault(status_t code);
    fault_code = code;
    dec_phase  = DEC_FAULT;
    return code;
  endfunction

  function automatic out_item_t decode_beat(in_item_t beat);
    out_item_t   res;
    logic [31:0] word;
    logic        word_ready;
    res        = '0;
    word       = '0;
    word_ready = 1'b0;
    if (beat.opcode == OP_START) begin
      clear_decoder();
    end else if (dec_phase == DEC_FAULT) begin
      res.status = fault_code;
    end else begin
      case (beat.opcode)
        OP_DATA: begin
          if (dec_phase == DEC_HEADER || dec_phase == DEC_RUN_RECORD) begin
            // four bytes little-endian make one header or run record
            if (byte_cnt < 2'd3) begin
              byte_acc = byte_acc | (24'(beat.data_byte) << (8 * byte_cnt));
              byte_cnt = byte_cnt + 2'd1;
            end else begin
              word       = {beat.data_byte, byte_acc};
              byte_acc   = '0;
              byte_cnt   = '0;
              word_ready = 1'b1;
            end
            if (word_ready && dec_phase == DEC_HEADER) begin
              img_w = word[15:0];
              img_h = word[31:16];
              if (img_w == 16'd0 || img_h == 16'd0)
                res.status = raise_fault(ST_ZERO_SIZE);
              else if (cfg_check && (img_w != cfg_exp_w || img_h != cfg_exp_h))
                res.status = raise_fault(ST_MISMATCH);
              else
                dec_phase = DEC_RUN_RECORD;
            end else if (word_ready) begin
              run_cnt = word[15:0];
              run_rgb = word[31:16];
              if (run_cnt == 16'd0)
                res.status = raise_fault(ST_ZERO_RUN);
              else
                dec_phase = DEC_PIXELS;
            end
          end else if (dec_phase == DEC_TAIL) begin
            res.status = raise_fault(ST_TRAILING);
          end else begin
            res.status = ST_NOTREADY;
          end
        end
        OP_PULL: begin
          if (dec_phase == DEC_PIXELS) begin
            res.pixel_valid = 1'b1;
            res.pixel_color = run_rgb;
            // column mirrored, rows counted from the bottom
            res.pixel_x = 17'(cfg_x_org) + 17'(img_w - 16'd1 - col_pos);
            res.pixel_y = 17'(cfg_y_org) + 17'(img_h - 16'd1 - row_pos);
            run_cnt = run_cnt - 16'd1;
            col_pos = col_pos + 16'd1;
            if (col_pos >= img_w) begin
              col_pos = '0;
              row_pos = row_pos + 16'd1;
            end
            if (row_pos >= img_h) begin
              res.frame_done = 1'b1;
              if (run_cnt != 16'd0)
                res.status = raise_fault(ST_LEFTOVER);
              else
                dec_phase = DEC_TAIL;
            end else if (run_cnt == 16'd0) begin
              dec_phase = DEC_RUN_RECORD;
            end
          end else begin
            res.status = ST_NOTREADY;
          end
        end
        default: begin
          if (dec_phase == DEC_HEADER || dec_phase == DEC_RUN_RECORD) begin
            res.status = raise_fault(ST_TRUNC);
          end else if (dec_phase == DEC_TAIL) begin
            dec_phase      = DEC_DONE;
            res.frame_done = 1'b1;
          end else begin
            res.status = ST_NOTREADY;
          end
        end
      endcase
    end
    res.need_byte = (dec_phase == DEC_HEADER || dec_phase == DEC_RUN_RECORD);
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: %p", got);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("status", 17'(want.status), 17'(got.status));
      check_field("pixel_valid", 17'(want.pixel_valid), 17'(got.pixel_valid));
      check_field("pixel_color", 17'(want.pixel_color), 17'(got.pixel_color));
      check_field("pixel_x", want.pixel_x, got.pixel_x);
      check_field("pixel_y", want.pixel_y, got.pixel_y);
      check_field("frame_done", 17'(want.frame_done), 17'(got.frame_done));
      check_field("need_byte", 17'(want.need_byte), 17'(got.need_byte));
    end
  endfunction

  // Input driver
  int unsigned send_gap;

  always @(posedge clk) begin
    logic stalled;
    stalled = in_valid && !in_ready;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!stalled) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks result beats, predicts on input beats, drives out_ready
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned results_seen;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap     = 0;
      hold_left    = 0;
      results_seen = 0;
      reset_decoder();
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        results_seen++;
        recv_gap = pick_gap();
        // long back-pressure so the result register fills and in_ready drops
        if (results_seen % 400 == 150)
          hold_left = 80;
      end
      if (in_valid && in_ready)
        expected_results.push_back(decode_beat(in_data));
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus helpers
  task automatic add_beat(opcode_t op, logic [7:0] b);
    in_item_t beat;
    beat.opcode    = op;
    beat.data_byte = b;
    pending_beats.push_back(beat);
    stim_items++;
  endtask

  task automatic add_op(opcode_t op);
    add_beat(op, 8'($urandom));
  endtask

  // misplaced requests; answered not-ready unless the frame has already failed, and left out of the item count
  task automatic add_stray(opcode_t op);
    in_item_t beat;
    beat.opcode    = op;
    beat.data_byte = 8'($urandom);
    pending_beats.push_back(beat);
  endtask

  task automatic add_word16(logic [15:0] v);
    add_beat(OP_DATA, v[7:0]);
    add_beat(OP_DATA, v[15:8]);
  endtask

  task automatic add_sticky_tail();
    repeat ($urandom_range(1, 3))
      add_beat(opcode_t'($urandom_range(0, 2)), 8'($urandom));
  endtask

  task automatic add_frame(logic [15:0] w, logic [15:0] h, frame_kind_e kind, bit stray);
    int unsigned left;
    int unsigned n;
    logic [15:0] count;
    bit          last_run;
    bit          cut;
    cut = 1'b0;
    add_op(OP_START);
    if (kind == FRAME_NOISE) begin
      repeat ($urandom_range(3, 10))
        add_beat(opcode_t'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    if (kind == FRAME_TRUNCATED && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 3))
        add_beat(OP_DATA, 8'($urandom));
      add_op(OP_EOF);
      add_sticky_tail();
      return;
    end
    add_word16(w);
    add_word16(h);
    left = int'(w) * int'(h);
    while (left > 0) begin
      n = ($urandom_range(0, 3) == 0) ? left : $urandom_range(1, (left < 8) ? left : 8);
      last_run = (n == left);
      if (stray && $urandom_range(0, 3) == 0)
        add_stray(OP_PULL);
      if (kind == FRAME_TRUNCATED && (last_run || $urandom_range(0, 2) == 0)) begin
        repeat ($urandom_range(0, 3))
          add_beat(OP_DATA, 8'($urandom));
        if ($urandom_range(0, 3) != 0)
          add_op(OP_EOF);
        cut = 1'b1;
        break;
      end
      if (kind == FRAME_ZERO_RUN && (last_run || $urandom_range(0, 2) == 0)) begin
        add_word16(16'h0000);
        add_word16(16'($urandom));
        cut = 1'b1;
        break;
      end
      count = 16'(n);
      if (kind == FRAME_LEFTOVER && last_run)
        count = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'(n + $urandom_range(1, 3));
      add_word16(count);
      add_word16(16'($urandom));
      repeat (n) begin
        if (stray && $urandom_range(0, 7) == 0)
          add_stray($urandom_range(0, 1) ? OP_DATA : OP_EOF);
        add_op(OP_PULL);
      end
      left -= n;
    end
    if (cut || kind == FRAME_LEFTOVER) begin
      add_sticky_tail();
    end else begin
      if (stray)
        add_stray(OP_PULL);
      if (kind == FRAME_TRAILING)
        add_beat(OP_DATA, 8'($urandom));
      add_op(OP_EOF);
      if (stray)
        add_stray(opcode_t'($urandom_range(0, 2)));
    end
  endtask

  task automatic add_random_frames(int unsigned quota, logic [15:0] ew, logic [15:0] eh,
                                   bit chk);
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] w, h;
    frame_kind_e kind;
    stop_at = stim_items + quota;
    while (stim_items < stop_at) begin
      if (chk && $urandom_range(0, 3) != 0) begin
        w = ew;
        h = eh;
      end else begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 4));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        w = '0;
      end else if (pick == 1) begin
        h = '0;
      end else if (pick == 2) begin
        w = 16'($urandom_range(20, 48));
        h = 16'd1;
      end
      pick = $urandom_range(0, 9);
      kind = (pick < 5) ? FRAME_CLEAN : frame_kind_e'(pick - 4);
      add_frame(w, h, kind, $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EXPECTED_WIDTH:  cfg_exp_w = val;
      CFG_EXPECTED_HEIGHT: cfg_exp_h = val;
      CFG_CHECK_SIZE:      cfg_check = val[0];
      CFG_X_ORIGIN:        cfg_x_org = val[9:0];
      CFG_Y_ORIGIN:        cfg_y_org = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] ew, logic [15:0] eh, bit chk,
                            logic [9:0] xo, logic [9:0] yo);
    write_reg(CFG_EXPECTED_WIDTH, ew);
    write_reg(CFG_EXPECTED_HEIGHT, eh);
    write_reg(CFG_CHECK_SIZE, 16'(chk));
    write_reg(CFG_X_ORIGIN, 16'(xo));
    write_reg(CFG_Y_ORIGIN, 16'(yo));
    cfg_valid <= 1'b0;
  endtask

  // returns on a rising edge once all beats are in and all results are out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] ew, eh;
    bit          chk;
    logic [9:0]  xo, yo;
    int unsigned quota;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // straight out of reset: pull too early, end of file in the header, sticky error
    add_op(OP_PULL);
    add_op(OP_EOF);
    add_beat(OP_DATA, 8'hA5);
    wait_idle();

    // extreme origins and sizes: widest and tallest frames
    set_config(16'hFFFF, 16'hFFFF, 1'b0, 10'h3FF, 10'h3FF);
    @(negedge clk);
    add_op(OP_START);
    add_word16(16'hFFFF);
    add_word16(16'h0001);
    add_word16(16'hFFFF);
    add_word16(16'hFFFF);
    add_op(OP_PULL);
    add_op(OP_PULL);
    add_op(OP_START);
    add_word16(16'h0001);
    add_word16(16'hFFFF);
    add_word16(16'h0002);
    add_word16(16'h0000);
    add_op(OP_PULL);
    add_op(OP_PULL);
    add_op(OP_EOF);
    wait_idle();

    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      quota = 100;
      case (phase_no)
        0: begin
          ew = 16'($urandom_range(1, 6)); eh = 16'($urandom_range(1, 4)); chk = 1'b1;
          xo = '0; yo = '0;
        end
        1: begin
          ew = '0; eh = '0; chk = 1'b1;
          xo = 10'($urandom); yo = 10'($urandom);
          quota = 50;
        end
        2: begin
          ew = 16'($urandom); eh = 16'($urandom); chk = 1'b0;
          xo = 10'h3FF; yo = '0;
        end
        3: begin
          ew = EXPECTED_WIDTH_RST; eh = EXPECTED_HEIGHT_RST; chk = 1'b0;
          xo = X_ORIGIN_RST; yo = Y_ORIGIN_RST;
        end
        default: begin
          chk = 1'($urandom_range(0, 1));
          ew  = chk ? 16'($urandom_range(1, 6)) : 16'($urandom);
          eh  = chk ? 16'($urandom_range(1, 4)) : 16'($urandom);
          xo  = 10'($urandom_range(0, 1023));
          yo  = 10'($urandom_range(0, 1023));
        end
      endcase
      set_config(ew, eh, chk, xo, yo);
      @(negedge clk);
      no_idle = (phase_no == 3 || phase_no == 6);
      add_random_frames(quota, ew, eh, chk);
      wait_idle();
    end

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ rle_rgb565_frame_decoder.f @@
+incdir+design
design/rlefd_pkg.sv
design/rle_rgb565_frame_decoder.sv
design/rlefd_checker.sv
tb/rle_rgb565_frame_decoder_tb.sv
